@@ hdl/mmdc_pkg.sv @@
package mmdc_pkg;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam logic [3:0] TYPE_LOADER_CODE  = 4'd1;
    localparam logic [3:0] TYPE_LOADER_DATA  = 4'd2;
    localparam logic [3:0] TYPE_BOOT_CODE    = 4'd3;
    localparam logic [3:0] TYPE_BOOT_DATA    = 4'd4;
    localparam logic [3:0] TYPE_CONVENTIONAL = 4'd7;

    typedef struct packed {
        logic [3:0]  mem_type;
        logic [63:0] phys_start;
        logic [63:0] virt_start;
        logic [63:0] page_count;
        logic [63:0] attr_bits;
        logic        last_in;
    } t_desc_in;

    typedef struct packed {
        logic [3:0]  out_type;
        logic [63:0] out_phys_start;
        logic [63:0] out_virt_start;
        logic [63:0] out_page_count;
        logic [63:0] out_attr_bits;
        logic        last_out;
    } t_desc_out;

    typedef struct packed {
        logic        valid;
        logic [3:0]  mem_type;
        logic [63:0] phys;
        logic [63:0] virt;
        logic [63:0] pages;
        logic [63:0] attr;
    } t_held;

    function automatic logic type_joinable(input logic [3:0] t);
        return (t == TYPE_LOADER_CODE) || (t == TYPE_LOADER_DATA) ||
               (t == TYPE_BOOT_CODE) || (t == TYPE_BOOT_DATA) ||
               (t == TYPE_CONVENTIONAL);
    endfunction

endpackage

@@ hdl/memory_map_descriptor_coalescer.sv @@
// Flow: an accepted request is taken into the input register, merged with the held
// descriptor, and its results are written into the result queue, then offered.
// Throughput: one descriptor per cycle while the result queue has room; a non-merging
// last descriptor yields two results, which leave through the two-entry result queue
// one per cycle while the output is not stalled. Reset (synchronous, active low)
// empties the input register, the result queue and the held descriptor.
module memory_map_descriptor_coalescer
    import mmdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_desc_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_desc_out o_out_data
);

    logic       r_in_valid;
    t_desc_in   r_in;
    t_held      r_held;
    logic [1:0] r_cnt;
    t_desc_out  r_q0;
    t_desc_out  r_q1;

    logic       n_in_valid;
    t_held      n_held;
    logic [1:0] n_cnt;
    t_desc_out  n_q0;
    t_desc_out  n_q1;

    logic [1:0] num_res;
    t_desc_out  res0;
    t_desc_out  res1;
    t_held      merged;
    logic       pop;
    logic [1:0] remain;
    logic [2:0] fill;
    logic       go;

    mmdc_merge u_merge (
        .i_held    (r_held),
        .i_desc    (r_in),
        .o_num_res (num_res),
        .o_res0    (res0),
        .o_res1    (res1),
        .o_held    (merged)
    );

    assign pop    = (r_cnt != 2'd0) && !i_out_stall;
    assign remain = r_cnt - {1'b0, pop};
    assign fill   = {1'b0, remain} + {1'b0, num_res};
    assign go     = r_in_valid && (fill <= 3'd2);

    assign o_in_stall  = r_in_valid && !go;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q0;

    always_comb begin
        n_q0   = r_q0;
        n_q1   = r_q1;
        n_cnt  = remain;
        n_held = r_held;
        if (pop) begin
            n_q0 = r_q1;
        end
        if (go) begin
            n_held = merged;
            n_cnt  = fill[1:0];
            if (num_res != 2'd0) begin
                if (remain == 2'd0) begin
                    n_q0 = res0;
                    n_q1 = res1;
                end else begin
                    n_q1 = res0;
                end
            end
        end
        n_in_valid = i_in_valid || o_in_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_cnt        <= 2'd0;
            r_held.valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
            r_held     <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

@@ hdl/mmdc_merge.sv @@
module mmdc_merge
    import mmdc_pkg::*;
(
    input  t_held      i_held,
    input  t_desc_in   i_desc,
    output logic [1:0] o_num_res,
    output t_desc_out  o_res0,
    output t_desc_out  o_res1,
    output t_held      o_held
);

    logic [63:0] held_end;
    logic        join_ok;
    t_held       fresh;
    t_desc_out   held_res;
    t_desc_out   fresh_res;

    assign held_end = i_held.phys + {i_held.pages[63-PAGE_SHIFT:0], {PAGE_SHIFT{1'b0}}};
    assign join_ok  = i_held.valid && (i_desc.attr_bits == i_held.attr) &&
                      (held_end == i_desc.phys_start) &&
                      type_joinable(i_desc.mem_type) && type_joinable(i_held.mem_type);

    always_comb begin
        fresh.valid    = 1'b1;
        fresh.mem_type = i_desc.mem_type;
        fresh.phys     = i_desc.phys_start;
        fresh.virt     = i_desc.virt_start;
        fresh.pages    = i_desc.page_count;
        fresh.attr     = i_desc.attr_bits;

        held_res = '{out_type: i_held.mem_type, out_phys_start: i_held.phys,
                     out_virt_start: i_held.virt, out_page_count: i_held.pages,
                     out_attr_bits: i_held.attr, last_out: 1'b0};

        o_num_res = 2'd0;
        o_res0    = held_res;
        o_res1    = held_res;

        if (join_ok) begin
            o_held          = i_held;
            o_held.mem_type = TYPE_CONVENTIONAL;
            o_held.pages    = i_held.pages + i_desc.page_count;
        end else begin
            o_held = fresh;
            if (i_held.valid) begin
                o_num_res = 2'd1;
            end
        end

        fresh_res = '{out_type: o_held.mem_type, out_phys_start: o_held.phys,
                      out_virt_start: o_held.virt, out_page_count: o_held.pages,
                      out_attr_bits: o_held.attr, last_out: 1'b1};

        // flush whatever is held after this request
        if (i_desc.last_in) begin
            if (o_num_res == 2'd1) begin
                o_res1 = fresh_res;
            end else begin
                o_res0 = fresh_res;
            end
            o_num_res   = o_num_res + 2'd1;
            o_held.valid = 1'b0;
        end
    end

endmodule

@@ hdl/mmdc_checker.sv @@
module mmdc_checker
    import mmdc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_desc_out o_out_data
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the queue and input register");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while the result queue is empty");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

endmodule

bind memory_map_descriptor_coalescer mmdc_checker u_mmdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ bench/memory_map_descriptor_coalescer_tb.sv @@
`timescale 1ns / 100ps

module memory_map_descriptor_coalescer_tb;
    import mmdc_pkg::*;

    class coalesce_scoreboard;
        bit          held_valid;
        logic [3:0]  held_type;
        logic [63:0] held_phys;
        logic [63:0] held_virt;
        logic [63:0] held_pages;
        logic [63:0] held_attr;
        t_desc_out   expected_descs[$];
        int unsigned mismatches;
        int unsigned requests;
        int unsigned results;
        int unsigned merges;
        int unsigned double_flushes;

        function new();
            clear_held();
        endfunction

        function void clear_held();
            held_valid = 1'b0;
            held_type  = '0;
            held_phys  = '0;
            held_virt  = '0;
            held_pages = '0;
            held_attr  = '0;
        endfunction

        function bit mergeable(input logic [3:0] t);
            case (t)
                TYPE_LOADER_CODE, TYPE_LOADER_DATA, TYPE_BOOT_CODE, TYPE_BOOT_DATA,
                TYPE_CONVENTIONAL: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void emit_held(input bit last);
            t_desc_out r;
            r.out_type       = held_type;
            r.out_phys_start = held_phys;
            r.out_virt_start = held_virt;
            r.out_page_count = held_pages;
            r.out_attr_bits  = held_attr;
            r.last_out       = last;
            expected_descs.push_back(r);
        endfunction

        function void hold_desc(input t_desc_in d);
            held_valid = 1'b1;
            held_type  = d.mem_type;
            held_phys  = d.phys_start;
            held_virt  = d.virt_start;
            held_pages = d.page_count;
            held_attr  = d.attr_bits;
        endfunction

        function void note_request(input t_desc_in d);
            logic [63:0] held_end;
            bit          emitted;
            requests++;
            emitted  = 1'b0;
            held_end = held_phys + (held_pages << PAGE_SHIFT);
            if (!held_valid) begin
                hold_desc(d);
            end else if (d.attr_bits == held_attr && d.phys_start == held_end &&
                         mergeable(d.mem_type) && mergeable(held_type)) begin
                held_type  = TYPE_CONVENTIONAL;
                held_pages = held_pages + d.page_count;
                merges++;
            end else begin
                emit_held(1'b0);
                emitted = 1'b1;
                hold_desc(d);
            end
            if (d.last_in) begin
                if (emitted) double_flushes++;
                emit_held(1'b1);
                clear_held();
            end
        endfunction

        function void compare_field(input string name, input logic [63:0] exp_val,
                                    input logic [63:0] act_val);
            if (act_val !== exp_val) begin
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, exp_val, act_val);
                mismatches++;
            end
        endfunction

        function void check_result(input t_desc_out got);
            t_desc_out want;
            results++;
            if (expected_descs.size() == 0) begin
                $display("%0t: unexpected descriptor: expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = expected_descs.pop_front();
                compare_field("out_type", 64'(want.out_type), 64'(got.out_type));
                compare_field("out_phys_start", want.out_phys_start, got.out_phys_start);
                compare_field("out_virt_start", want.out_virt_start, got.out_virt_start);
                compare_field("out_page_count", want.out_page_count, got.out_page_count);
                compare_field("out_attr_bits", want.out_attr_bits, got.out_attr_bits);
                compare_field("last_out", 64'(want.last_out), 64'(got.last_out));
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_desc_in  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_desc_out o_out_data;

    coalesce_scoreboard sb = new();

    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned sent = 0;
    logic [63:0] chain_end = '0;
    logic [63:0] chain_attr = '0;

    memory_map_descriptor_coalescer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #2_000_000;
        $display("FAIL memory_map_descriptor_coalescer");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idle_on && ($urandom_range(99) < 27);
            end
        end
    end

    function automatic t_desc_in make_desc(input logic [3:0] t, input logic [63:0] phys,
                                           input logic [63:0] virt, input logic [63:0] pages,
                                           input logic [63:0] attr, input bit last);
        t_desc_in d;
        d.mem_type   = t;
        d.phys_start = phys;
        d.virt_start = virt;
        d.page_count = pages;
        d.attr_bits  = attr;
        d.last_in    = last;
        return d;
    endfunction

    function automatic logic [3:0] pick_joinable_type();
        case ($urandom_range(4))
            0: return TYPE_LOADER_CODE;
            1: return TYPE_LOADER_DATA;
            2: return TYPE_BOOT_CODE;
            3: return TYPE_BOOT_DATA;
            default: return TYPE_CONVENTIONAL;
        endcase
    endfunction

    task automatic send_desc(input t_desc_in d);
        while (idle_on && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(d);
        sent++;
        chain_end  = d.phys_start + (d.page_count << PAGE_SHIFT);
        chain_attr = d.attr_bits;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_descs.size() != 0);
    endtask

    // mostly contiguous runs with matching attributes, with near misses and noise
    task automatic send_random_map(input int unsigned len, input bit flush);
        t_desc_in    d;
        int unsigned k;
        for (k = 0; k < len; k++) begin
            d.virt_start = {$urandom, $urandom};
            d.last_in    = flush && (k == len - 1);
            if (k != 0 && $urandom_range(99) < 75) begin
                d.mem_type   = pick_joinable_type();
                d.phys_start = chain_end;
                d.attr_bits  = chain_attr;
                case ($urandom_range(19))
                    0: d.phys_start = chain_end + 64'h1000;
                    1: d.attr_bits = chain_attr ^ (64'd1 << $urandom_range(63));
                    2: d.mem_type = 4'($urandom_range(15));
                    3: d.phys_start = chain_end ^ (64'd1 << $urandom_range(63));
                    default: ;
                endcase
            end else begin
                d.mem_type   = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                        : pick_joinable_type();
                d.phys_start = {$urandom, $urandom};
                if ($urandom_range(1)) d.phys_start[11:0] = '0;
                case ($urandom_range(3))
                    0: d.attr_bits = '0;
                    1: d.attr_bits = 64'h8000_0000_0000_000F;
                    default: d.attr_bits = {$urandom, $urandom};
                endcase
            end
            case ($urandom_range(9))
                0, 1: d.page_count = {$urandom, $urandom};
                2: d.page_count = '1 - 64'($urandom_range(3));
                default: d.page_count = 64'($urandom_range(64));
            endcase
            send_desc(d);
        end
    endtask

    initial begin : stimulus
        int unsigned rand_start;
        bit          hold_done;
        bit          pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-descriptor maps, field extremes
        send_desc(make_desc(TYPE_LOADER_CODE, 64'h1000, 64'hA000, 64'd1, 64'h0, 1'b1));
        send_desc(make_desc(4'hF, '1, '1, '1, '1, 1'b1));
        send_desc(make_desc(4'h0, '0, '0, '0, '0, 1'b1));

        // merge chain through every joinable type, zero pages included
        send_desc(make_desc(TYPE_LOADER_CODE, 64'h10_0000, 64'h1, 64'd2, 64'hF, 1'b0));
        send_desc(make_desc(TYPE_LOADER_DATA, 64'h10_2000, 64'h2, 64'd3, 64'hF, 1'b0));
        send_desc(make_desc(TYPE_BOOT_CODE, 64'h10_5000, 64'h3, 64'd1, 64'hF, 1'b0));
        send_desc(make_desc(TYPE_BOOT_DATA, 64'h10_6000, 64'h4, 64'd4, 64'hF, 1'b0));
        send_desc(make_desc(TYPE_CONVENTIONAL, 64'h10_A000, 64'h5, 64'd0, 64'hF, 1'b0));
        send_desc(make_desc(TYPE_LOADER_CODE, 64'h10_A000, 64'h6, 64'd5, 64'hF, 1'b1));

        // breaks: attributes, address gap, other type codes, unmerged last
        send_desc(make_desc(TYPE_CONVENTIONAL, 64'h20_0000, 64'h7, 64'd1, 64'h1, 1'b0));
        send_desc(make_desc(TYPE_CONVENTIONAL, 64'h20_1000, 64'h8, 64'd1, 64'h3, 1'b0));
        send_desc(make_desc(TYPE_CONVENTIONAL, 64'h20_3000, 64'h9, 64'd1, 64'h3, 1'b0));
        send_desc(make_desc(4'd5, 64'h20_4000, 64'hA, 64'd1, 64'h3, 1'b0));
        send_desc(make_desc(TYPE_CONVENTIONAL, 64'h20_5000, 64'hB, 64'd1, 64'h3, 1'b1));
        send_desc(make_desc(4'd6, 64'h30_0000, 64'hC, 64'd1, 64'h0, 1'b0));
        send_desc(make_desc(4'd6, 64'h30_1000, 64'hD, 64'd1, 64'h0, 1'b1));

        // end address and page total both wrap
        send_desc(make_desc(TYPE_BOOT_DATA, 64'hFFFF_FFFF_FFFF_F000, 64'hE, 64'd1,
                            64'h0, 1'b0));
        send_desc(make_desc(TYPE_LOADER_DATA, 64'h0, 64'hF, '1, 64'h0, 1'b0));
        send_desc(make_desc(TYPE_CONVENTIONAL, 64'hFFFF_FFFF_FFFF_F000, 64'h10, 64'd3,
                            64'h0, 1'b1));
        drain_results();

        rand_start = sent;
        while (sent < rand_start + 1950) begin
            if (!hold_done && sent >= rand_start + 500) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            idle_on = !(sent >= rand_start + 900 && sent < rand_start + 1200);
            if (!pause_done && sent >= rand_start + 1400) begin
                drain_results();
                pause_done = 1'b1;
            end
            send_random_map($urandom_range(1, 12), $urandom_range(9) != 0);
        end
        send_random_map(2, 1'b1);

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Coalesced %0d descriptor requests with %0d merges;", sb.requests,
                 sb.merges);
        $display("checked %0d results; %0d unmerged last descriptors flushed two at once.",
                 sb.results, sb.double_flushes);
        if (sb.mismatches == 0 && sb.expected_descs.size() == 0) begin
            $display("PASS memory_map_descriptor_coalescer");
        end else begin
            $display("FAIL memory_map_descriptor_coalescer");
        end
        $finish;
    end

endmodule
